>>> rtl/core/ecpoc_pkg.sv
// ---------------------------------------------------------------------------
// ecpoc_pkg
// Shared types, opcodes and register indexes for the point order checker.
// ---------------------------------------------------------------------------
package ecpoc_pkg;

  localparam int MOD_WIDTH_DEF    = 16;
  localparam int SCALAR_WIDTH_DEF = 16;
  localparam int ENERGY_WIDTH     = 32;

  // register file indexes
  localparam int REG_IDX_WIDTH = 5;
  localparam logic [REG_IDX_WIDTH-1:0] R_N   = 5'd0;
  localparam logic [REG_IDX_WIDTH-1:0] R_A   = 5'd1;
  localparam logic [REG_IDX_WIDTH-1:0] R_B   = 5'd2;
  localparam logic [REG_IDX_WIDTH-1:0] R_GX  = 5'd3;
  localparam logic [REG_IDX_WIDTH-1:0] R_GY  = 5'd4;
  localparam logic [REG_IDX_WIDTH-1:0] R_AX  = 5'd5;
  localparam logic [REG_IDX_WIDTH-1:0] R_AY  = 5'd6;
  localparam logic [REG_IDX_WIDTH-1:0] R_AZ  = 5'd7;
  localparam logic [REG_IDX_WIDTH-1:0] R_CX  = 5'd8;
  localparam logic [REG_IDX_WIDTH-1:0] R_CY  = 5'd9;
  localparam logic [REG_IDX_WIDTH-1:0] R_CZ  = 5'd10;
  localparam logic [REG_IDX_WIDTH-1:0] R_T0  = 5'd11;
  localparam logic [REG_IDX_WIDTH-1:0] R_T1  = 5'd12;
  localparam logic [REG_IDX_WIDTH-1:0] R_T2  = 5'd13;
  localparam logic [REG_IDX_WIDTH-1:0] R_T3  = 5'd14;
  localparam logic [REG_IDX_WIDTH-1:0] R_T4  = 5'd15;
  localparam logic [REG_IDX_WIDTH-1:0] R_T5  = 5'd16;
  localparam logic [REG_IDX_WIDTH-1:0] R_T6  = 5'd17;
  localparam logic [REG_IDX_WIDTH-1:0] R_T7  = 5'd18;
  localparam logic [REG_IDX_WIDTH-1:0] R_ERR = 5'd19;
  localparam logic [REG_IDX_WIDTH-1:0] R_ONE = 5'd20;
  localparam int NUM_REGS = 21;

  // datapath operations
  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_COPY = 3'd4;

  typedef struct packed {
    logic                     start;
    logic [2:0]               op;
    logic [REG_IDX_WIDTH-1:0] src_a;
    logic [REG_IDX_WIDTH-1:0] src_b;
    logic [REG_IDX_WIDTH-1:0] dst;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic az_zero;
    logic cz_zero;
    logic t0_eq_t1;
    logic t2_eq_t3;
  } dp_stat_t;

endpackage

>>> rtl/core/ecpoc_datapath.sv
// ---------------------------------------------------------------------------
// ecpoc_datapath
// Register file and shared modular unit; one bit of product per cycle.
// ---------------------------------------------------------------------------
module ecpoc_datapath
  import ecpoc_pkg::*;
#(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [MOD_WIDTH-1:0] in_n,
  input  logic [MOD_WIDTH-1:0] in_a,
  input  logic [MOD_WIDTH-1:0] in_b,
  input  logic [MOD_WIDTH-1:0] in_gx,
  input  logic [MOD_WIDTH-1:0] in_gy,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [MOD_WIDTH-1:0] err_out,
  output logic [MOD_WIDTH-1:0] az_sq_out
);

  localparam int CW = $clog2(MOD_WIDTH + 1);

  logic [MOD_WIDTH-1:0] regs [NUM_REGS];
  logic                 busy;
  logic [2:0]           op;
  logic [REG_IDX_WIDTH-1:0] dst;
  logic [MOD_WIDTH-1:0] opa;
  logic [MOD_WIDTH-1:0] opb;
  logic [MOD_WIDTH-1:0] acc;
  logic [CW-1:0]        cnt;
  logic                 done;

  logic [MOD_WIDTH-1:0] n;
  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH-1:0] dbl_m;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH-1:0] sum_m;
  logic [MOD_WIDTH:0]   sub_w;
  logic [MOD_WIDTH-1:0] sub_m;

  assign n = regs[R_N];

  // doubling then conditional add, both reduced by one compare
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = dbl - {1'b0, n};
    dbl_m   = (dbl >= {1'b0, n}) ? dbl_red[MOD_WIDTH-1:0] : dbl[MOD_WIDTH-1:0];
    sum     = {1'b0, dbl_m} + {1'b0, (opa[MOD_WIDTH-1] ? opb : '0)};
    if (op != OP_MUL) begin
      sum = {1'b0, opa} + {1'b0, opb};
    end
    sum_m   = (sum >= {1'b0, n}) ? MOD_WIDTH'(sum - {1'b0, n}) : sum[MOD_WIDTH-1:0];
    sub_w   = {1'b0, opa} - {1'b0, opb};
    sub_m   = (opa >= opb) ? sub_w[MOD_WIDTH-1:0] : MOD_WIDTH'(sub_w + {1'b0, n});
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (load) begin
      regs[R_N]  <= in_n;
      regs[R_A]  <= in_a;
      regs[R_B]  <= in_b;
      regs[R_GX] <= in_gx;
      regs[R_GY] <= in_gy;
      regs[R_ONE] <= MOD_WIDTH'(1);
    end else if (cmd.start) begin
      busy <= 1'b1;
      op   <= cmd.op;
      dst  <= cmd.dst;
      opa  <= regs[cmd.src_a];
      opb  <= regs[cmd.src_b];
      acc  <= '0;
      cnt  <= CW'(MOD_WIDTH);
    end else if (busy) begin
      unique case (op)
        OP_MUL: begin
          acc <= sum_m;
          opa <= {opa[MOD_WIDTH-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            busy       <= 1'b0;
            done       <= 1'b1;
            regs[dst]  <= sum_m;
          end
        end
        OP_ADD: begin
          busy <= 1'b0; done <= 1'b1; regs[dst] <= sum_m;
        end
        OP_SUB: begin
          busy <= 1'b0; done <= 1'b1; regs[dst] <= sub_m;
        end
        default: begin
          busy <= 1'b0; done <= 1'b1; regs[dst] <= opa;
        end
      endcase
    end
  end

  assign stat.done     = done;
  assign stat.az_zero  = (regs[R_AZ] == '0);
  assign stat.cz_zero  = (regs[R_CZ] == '0);
  assign stat.t0_eq_t1 = (regs[R_T0] == regs[R_T1]);
  assign stat.t2_eq_t3 = (regs[R_T2] == regs[R_T3]);
  assign err_out       = regs[R_ERR];
  assign az_sq_out     = regs[R_T0];

endmodule

>>> rtl/core/ecpoc_ctrl.sv
// ---------------------------------------------------------------------------
// ecpoc_ctrl
// Sequencer: steps microprograms for curve check, load, add, infinity, double and finish.
// ---------------------------------------------------------------------------
module ecpoc_ctrl
  import ecpoc_pkg::*;
#(
  parameter int MOD_WIDTH    = MOD_WIDTH_DEF,
  parameter int SCALAR_WIDTH = SCALAR_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [MOD_WIDTH-1:0]    in_n,
  input  logic [SCALAR_WIDTH-1:0] in_k,
  output logic                    in_stall,
  output logic                    load,
  output dp_cmd_t                 cmd,
  input  dp_stat_t                stat,
  input  logic [MOD_WIDTH-1:0]    err,
  input  logic [MOD_WIDTH-1:0]    az_sq,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ENERGY_WIDTH-1:0] energy,
  output logic                    certified,
  output logic                    bad_modulus
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SQ1 = 3'd3;
  localparam logic [2:0] S_SQ2 = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  // program segments
  localparam logic [2:0] P_INIT = 3'd0;
  localparam logic [2:0] P_ADD  = 3'd1;
  localparam logic [2:0] P_ADD2 = 3'd2;
  localparam logic [2:0] P_DBL  = 3'd3;
  localparam logic [2:0] P_FIN  = 3'd4;
  localparam logic [2:0] P_LOAD = 3'd5;
  localparam logic [2:0] P_INF  = 3'd6;

  localparam int PCW = 6;

  logic [2:0]              state;
  logic [2:0]              seg;
  logic [PCW-1:0]          pc;
  logic [SCALAR_WIDTH-1:0] k;
  logic [2*MOD_WIDTH-1:0]  sq;
  logic [MOD_WIDTH-1:0]    mult;
  logic [ENERGY_WIDTH-1:0] en_w;
  dp_cmd_t                 uop;
  logic                    last;

  function automatic dp_cmd_t mk(logic [2:0] o, logic [REG_IDX_WIDTH-1:0] a,
                                 logic [REG_IDX_WIDTH-1:0] b,
                                 logic [REG_IDX_WIDTH-1:0] d);
    dp_cmd_t c;
    c.start = 1'b1; c.op = o; c.src_a = a; c.src_b = b; c.dst = d;
    return c;
  endfunction

  // microcode
  always_comb begin
    uop  = mk(OP_COPY, R_ONE, R_ONE, R_T7);
    last = 1'b0;
    unique case (seg)
      P_INIT: begin
        // reduce operands by multiplying with one, then compute the curve error and set the start points
        unique case (pc)
          6'd0:  uop = mk(OP_MUL, R_A, R_ONE, R_A);
          6'd1:  uop = mk(OP_MUL, R_B, R_ONE, R_B);
          6'd2:  uop = mk(OP_MUL, R_GX, R_ONE, R_GX);
          6'd3:  uop = mk(OP_MUL, R_GY, R_ONE, R_GY);
          6'd4:  uop = mk(OP_MUL, R_GY, R_GY, R_T0);
          6'd5:  uop = mk(OP_MUL, R_GX, R_GX, R_T1);
          6'd6:  uop = mk(OP_MUL, R_T1, R_GX, R_T1);
          6'd7:  uop = mk(OP_MUL, R_A, R_GX, R_T2);
          6'd8:  uop = mk(OP_ADD, R_T1, R_T2, R_T1);
          6'd9:  uop = mk(OP_ADD, R_T1, R_B, R_T1);
          6'd10: uop = mk(OP_SUB, R_T0, R_T1, R_ERR);
          6'd11: uop = mk(OP_COPY, R_GX, R_GX, R_CX);
          6'd12: uop = mk(OP_COPY, R_GY, R_GY, R_CY);
          6'd13: uop = mk(OP_COPY, R_ONE, R_ONE, R_CZ);
          6'd14: uop = mk(OP_COPY, R_ONE, R_ONE, R_AY);
          6'd15: uop = mk(OP_SUB, R_ONE, R_ONE, R_AX);
          default: begin
            uop = mk(OP_SUB, R_ONE, R_ONE, R_AZ); last = 1'b1;
          end
        endcase
      end
      P_LOAD: begin
        unique case (pc)
          6'd0: uop = mk(OP_COPY, R_CX, R_CX, R_AX);
          6'd1: uop = mk(OP_COPY, R_CY, R_CY, R_AY);
          default: begin
            uop = mk(OP_COPY, R_CZ, R_CZ, R_AZ); last = 1'b1;
          end
        endcase
      end
      P_INF: begin
        unique case (pc)
          6'd0: uop = mk(OP_SUB, R_ONE, R_ONE, R_AX);
          6'd1: uop = mk(OP_COPY, R_ONE, R_ONE, R_AY);
          default: begin
            uop = mk(OP_SUB, R_ONE, R_ONE, R_AZ); last = 1'b1;
          end
        endcase
      end
      P_ADD: begin
        // T4=z1s T5=z2s T0=u1 T1=u2 T2=s1 T3=s2
        unique case (pc)
          6'd0: uop = mk(OP_MUL, R_AZ, R_AZ, R_T4);
          6'd1: uop = mk(OP_MUL, R_CZ, R_CZ, R_T5);
          6'd2: uop = mk(OP_MUL, R_AX, R_T5, R_T0);
          6'd3: uop = mk(OP_MUL, R_CX, R_T4, R_T1);
          6'd4: uop = mk(OP_MUL, R_T5, R_CZ, R_T6);
          6'd5: uop = mk(OP_MUL, R_AY, R_T6, R_T2);
          6'd6: uop = mk(OP_MUL, R_T4, R_AZ, R_T6);
          default: begin
            uop = mk(OP_MUL, R_CY, R_T6, R_T3); last = 1'b1;
          end
        endcase
      end
      P_ADD2: begin
        // T4=h T5=r T6=h2 T7=h3 T1=u1h2 ; T0 u1, T2 s1
        unique case (pc)
          6'd0:  uop = mk(OP_SUB, R_T1, R_T0, R_T4);
          6'd1:  uop = mk(OP_SUB, R_T3, R_T2, R_T5);
          6'd2:  uop = mk(OP_MUL, R_T4, R_T4, R_T6);
          6'd3:  uop = mk(OP_MUL, R_T6, R_T4, R_T7);
          6'd4:  uop = mk(OP_MUL, R_T0, R_T6, R_T1);
          6'd5:  uop = mk(OP_MUL, R_AZ, R_CZ, R_T6);
          6'd6:  uop = mk(OP_MUL, R_T6, R_T4, R_AZ);
          6'd7:  uop = mk(OP_MUL, R_T5, R_T5, R_T3);
          6'd8:  uop = mk(OP_SUB, R_T3, R_T7, R_T3);
          6'd9:  uop = mk(OP_ADD, R_T1, R_T1, R_T6);
          6'd10: uop = mk(OP_SUB, R_T3, R_T6, R_AX);
          6'd11: uop = mk(OP_SUB, R_T1, R_AX, R_T3);
          6'd12: uop = mk(OP_MUL, R_T5, R_T3, R_T3);
          6'd13: uop = mk(OP_MUL, R_T2, R_T7, R_T6);
          default: begin
            uop = mk(OP_SUB, R_T3, R_T6, R_AY); last = 1'b1;
          end
        endcase
      end
      P_DBL: begin
        // T0 xx, T1 zz->z4, T2 mm, T3 yy, T4 s, T5/T6 temps
        unique case (pc)
          6'd0:  uop = mk(OP_MUL, R_CX, R_CX, R_T0);
          6'd1:  uop = mk(OP_MUL, R_CZ, R_CZ, R_T1);
          6'd2:  uop = mk(OP_MUL, R_T1, R_T1, R_T1);
          6'd3:  uop = mk(OP_ADD, R_T0, R_T0, R_T2);
          6'd4:  uop = mk(OP_ADD, R_T2, R_T0, R_T2);
          6'd5:  uop = mk(OP_MUL, R_A, R_T1, R_T5);
          6'd6:  uop = mk(OP_ADD, R_T2, R_T5, R_T2);
          6'd7:  uop = mk(OP_MUL, R_CY, R_CY, R_T3);
          6'd8:  uop = mk(OP_ADD, R_CX, R_CX, R_T4);
          6'd9:  uop = mk(OP_ADD, R_T4, R_T4, R_T4);
          6'd10: uop = mk(OP_MUL, R_T4, R_T3, R_T4);
          6'd11: uop = mk(OP_MUL, R_T2, R_T2, R_T5);
          6'd12: uop = mk(OP_ADD, R_T4, R_T4, R_T6);
          6'd13: uop = mk(OP_SUB, R_T5, R_T6, R_T5);
          6'd14: uop = mk(OP_ADD, R_CY, R_CY, R_T6);
          6'd15: uop = mk(OP_MUL, R_T6, R_CZ, R_CZ);
          6'd16: uop = mk(OP_COPY, R_T5, R_T5, R_CX);
          6'd17: uop = mk(OP_SUB, R_T4, R_CX, R_T4);
          6'd18: uop = mk(OP_MUL, R_T2, R_T4, R_T4);
          6'd19: uop = mk(OP_MUL, R_T3, R_T3, R_T3);
          6'd20: uop = mk(OP_ADD, R_T3, R_T3, R_T3);
          6'd21: uop = mk(OP_ADD, R_T3, R_T3, R_T3);
          6'd22: uop = mk(OP_ADD, R_T3, R_T3, R_T3);
          default: begin
            uop = mk(OP_SUB, R_T4, R_T3, R_CY); last = 1'b1;
          end
        endcase
      end
      P_FIN: begin
        uop = mk(OP_MUL, R_AZ, R_AZ, R_T0); last = 1'b1;
      end
      default: begin
        uop = mk(OP_COPY, R_ONE, R_ONE, R_T7); last = 1'b1;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign load     = (state == S_IDLE) && in_valid && (in_n >= MOD_WIDTH'(2));

  always_comb begin
    cmd = uop;
    cmd.start = (state == S_ISSUE);
  end

  // energy: bit-serial square of the curve error (shift-add) plus AZ squared
  assign en_w = ENERGY_WIDTH'(sq) + ENERGY_WIDTH'(az_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_n < MOD_WIDTH'(2)) begin
              energy      <= '0;
              certified   <= 1'b0;
              bad_modulus <= 1'b1;
              out_valid   <= 1'b1;
              state       <= S_OUT;
            end else begin
              k     <= in_k;
              seg   <= P_INIT;
              pc    <= '0;
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (stat.done) begin
            state <= S_ISSUE;
            if (!last) begin
              pc <= pc + PCW'(1);
            end else begin
              pc <= '0;
              priority case (seg)
                P_ADD: begin
                  if (!stat.t0_eq_t1) seg <= P_ADD2;
                  else if (!stat.t2_eq_t3) seg <= P_INF;
                  else if (!stat.cz_zero) seg <= P_DBL;
                  else begin
                    k <= k >> 1;
                    seg <= P_INIT;
                    state <= S_SQ1;
                  end
                end
                P_DBL: begin
                  k <= k >> 1;
                  state <= S_SQ1;
                end
                P_ADD2, P_INF, P_LOAD: begin
                  if (!stat.cz_zero) seg <= P_DBL;
                  else begin
                    k <= k >> 1;
                    state <= S_SQ1;
                  end
                end
                P_FIN: begin
                  sq    <= '0;
                  mult  <= err;
                  pc    <= '0;
                  state <= S_SQ2;
                end
                default: state <= S_SQ1;
              endcase
            end
          end
        end
        S_SQ1: begin
          // bit dispatch: pick add/load for a set scalar bit, double for a clear bit, or finish
          pc <= '0;
          state <= S_ISSUE;
          if (k == '0) seg <= P_FIN;
          else if (!k[0]) begin
            if (!stat.cz_zero) seg <= P_DBL;
            else begin
              k <= k >> 1;
              state <= S_SQ1;
            end
          end else if (stat.az_zero) seg <= P_LOAD;
          else seg <= P_ADD;
        end
        S_SQ2: begin
          if (mult[0]) sq <= sq + ((2*MOD_WIDTH)'(err) << pc);
          mult <= mult >> 1;
          pc   <= pc + PCW'(1);
          if (mult == '0) begin
            energy      <= (mult[0] ? en_w : ENERGY_WIDTH'(sq) + ENERGY_WIDTH'(az_sq));
            certified   <= (en_w == '0);
            bad_modulus <= 1'b0;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/ec_point_order_check_unit.sv
// ---------------------------------------------------------------------------
// ec_point_order_check_unit
// Curve membership test and scalar multiple check in Jacobian coordinates.
// ---------------------------------------------------------------------------
// Input channel: modulus, coef_a, coef_b, base_x, base_y, scalar with
// in_valid / in_stall; one item is taken while the unit is idle.
// Output channel: energy, certified, bad_modulus with out_valid / out_stall.
// Each modular multiply runs bit-serially on the single shift-add
// multiplier, while add, sub and copy are single operations; operand
// reduction is a multiply by one. Per scalar bit up to 26 multiplies and 21
// other operations run, after a setup and before a final squaring;
// a modulus below 2 gives its result the cycle after the transfer.
// One item is in flight at a time; the shared multiplier sets the rate.
// Reset clears the controller to idle with no result pending.
// A stalled result is held on the output until taken; no new item is
// accepted until then.
// ---------------------------------------------------------------------------
module ec_point_order_check_unit
  import ecpoc_pkg::*;
#(
  parameter int MOD_WIDTH    = MOD_WIDTH_DEF,
  parameter int SCALAR_WIDTH = SCALAR_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MOD_WIDTH-1:0]    modulus,
  input  logic [MOD_WIDTH-1:0]    coef_a,
  input  logic [MOD_WIDTH-1:0]    coef_b,
  input  logic [MOD_WIDTH-1:0]    base_x,
  input  logic [MOD_WIDTH-1:0]    base_y,
  input  logic [SCALAR_WIDTH-1:0] scalar,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ENERGY_WIDTH-1:0] energy,
  output logic                    certified,
  output logic                    bad_modulus
);

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic                 load;
  logic [MOD_WIDTH-1:0] err;
  logic [MOD_WIDTH-1:0] az_sq;

  ecpoc_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
    .clk, .rst, .load,
    .in_n(modulus), .in_a(coef_a), .in_b(coef_b), .in_gx(base_x), .in_gy(base_y),
    .cmd, .stat, .err_out(err), .az_sq_out(az_sq)
  );

  ecpoc_ctrl #(.MOD_WIDTH(MOD_WIDTH), .SCALAR_WIDTH(SCALAR_WIDTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_n(modulus), .in_k(scalar), .in_stall, .load,
    .cmd, .stat, .err, .az_sq, .out_valid, .out_stall,
    .energy, .certified, .bad_modulus
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken with result pending");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(energy))
    else $error("stalled result changed");
  a_cert_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && certified |-> energy == '0 && !bad_modulus)
    else $error("certified with nonzero energy");
`endif

endmodule

>>> dv/tb_ec_point_order_check_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ec_point_order_check_unit
// Drives curve certificates into the point order checker with random idle
// and stall bursts, predicts energy and flags in a software model of the
// Jacobian double-and-add, and compares every result transfer in order.
// ---------------------------------------------------------------------------
module tb_ec_point_order_check_unit;
  import ecpoc_pkg::*;

  localparam int MW = MOD_WIDTH_DEF;
  localparam int SW = SCALAR_WIDTH_DEF;
  localparam int QUIET_LIMIT = 400000;

  typedef struct packed {
    logic [MW-1:0] n;
    logic [MW-1:0] a;
    logic [MW-1:0] b;
    logic [MW-1:0] gx;
    logic [MW-1:0] gy;
    logic [SW-1:0] m;
  } cert_t;

  typedef struct packed {
    logic [ENERGY_WIDTH-1:0] energy;
    logic                    certified;
    logic                    bad_modulus;
  } verdict_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [MW-1:0] modulus, coef_a, coef_b, base_x, base_y;
  logic [SW-1:0] scalar;
  logic [ENERGY_WIDTH-1:0] energy;
  logic certified, bad_modulus;

  cert_t    pending_certs[$];
  verdict_t expected_verdicts[$];
  int  error_count = 0;
  int  quiet_cycles = 0;
  bit  stim_done = 0;
  bit  calm = 0;
  int  in_gap = 0, out_hold = 0;

  ec_point_order_check_unit DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned mm(longint unsigned x, longint unsigned y,
                                          longint unsigned n);
    return (x * y) % n;
  endfunction

  function automatic longint unsigned ms(longint unsigned x, longint unsigned y,
                                          longint unsigned n);
    x %= n;
    y %= n;
    return (x >= y) ? x - y : x + n - y;
  endfunction

  function automatic verdict_t predict_verdict(cert_t c);
    verdict_t v;
    longint unsigned n, k, a, b, gx, gy, err, ax, ay, az, cx, cy, cz;
    longint unsigned z1s, z2s, u1, u2, s1, s2, h, r, h2, h3, u1h2, nx, ny;
    longint unsigned xx, zz, z4, q, yy, s, dx, dy;
    n = c.n;
    k = c.m;
    v = '0;
    if (n < 2) begin
      v.bad_modulus = 1'b1;
      return v;
    end
    a = c.a % n;
    b = c.b % n;
    gx = c.gx % n;
    gy = c.gy % n;
    err = ms(mm(gy, gy, n), (mm(mm(gx, gx, n), gx, n) + mm(a, gx, n) + b) % n, n);
    ax = 0; ay = 1; az = 0;
    cx = gx; cy = gy; cz = 1;
    while (k != 0) begin
      if (k[0]) begin
        if (az == 0) begin
          ax = cx; ay = cy; az = cz;
        end else begin
          z1s = mm(az, az, n);
          z2s = mm(cz, cz, n);
          u1 = mm(ax, z2s, n);
          u2 = mm(cx, z1s, n);
          s1 = mm(ay, mm(z2s, cz, n), n);
          s2 = mm(cy, mm(z1s, az, n), n);
          if (u1 == u2) begin
            if (s1 != s2) begin
              ax = 0; ay = 1; az = 0;
            end
          end else begin
            h = ms(u2, u1, n);
            r = ms(s2, s1, n);
            h2 = mm(h, h, n);
            h3 = mm(h2, h, n);
            u1h2 = mm(u1, h2, n);
            nx = ms(ms(mm(r, r, n), h3, n), mm(2, u1h2, n), n);
            ny = ms(mm(r, ms(u1h2, nx, n), n), mm(s1, h3, n), n);
            az = mm(mm(az, cz, n), h, n);
            ax = nx; ay = ny;
          end
        end
      end
      if (cz != 0) begin
        xx = mm(cx, cx, n);
        zz = mm(cz, cz, n);
        z4 = mm(zz, zz, n);
        q = (mm(3, xx, n) + mm(a, z4, n)) % n;
        yy = mm(cy, cy, n);
        s = mm(mm(4, cx, n), yy, n);
        dx = ms(mm(q, q, n), mm(2, s, n), n);
        dy = ms(mm(q, ms(s, dx, n), n), mm(8, mm(yy, yy, n), n), n);
        cz = mm(mm(2, cy, n), cz, n);
        cx = dx; cy = dy;
      end
      k >>= 1;
    end
    v.energy = ENERGY_WIDTH'(err * err + mm(az, az, n));
    v.certified = (v.energy == 0);
    return v;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic cert_t rand_cert(bit small_n);
    cert_t c;
    c.n = small_n ? MW'($urandom_range(2, 60)) : MW'($urandom);
    if (c.n >= 2 && $urandom_range(0, 9) != 0) begin
      c.a = MW'($urandom % c.n);
      c.b = MW'($urandom % c.n);
      c.gx = MW'($urandom % c.n);
      c.gy = MW'($urandom % c.n);
    end else begin
      c.a = MW'($urandom); c.b = MW'($urandom);
      c.gx = MW'($urandom); c.gy = MW'($urandom);
    end
    case ($urandom_range(0, 3))
      0: c.m = SW'($urandom_range(0, 70));
      1: c.m = SW'($urandom_range(0, 2 * c.n + 2));
      default: c.m = SW'($urandom);
    endcase
    return c;
  endfunction

  initial begin
    cert_t c;
    // curve y^2 = x^3 + 2x + 3 mod 97, point (3, 6) lies on it
    pending_certs.push_back('{16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd5});
    pending_certs.push_back('{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_certs.push_back('{16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    pending_certs.push_back('{16'd97, 16'd2, 16'd3, 16'd3, 16'd6, 16'd0});
    pending_certs.push_back('{16'd97, 16'd2, 16'd3, 16'd3, 16'd6, 16'd1});
    pending_certs.push_back('{16'd97, 16'd2, 16'd3, 16'd3, 16'd6, 16'd5});
    pending_certs.push_back('{16'd97, 16'd2, 16'd3, 16'd3, 16'd6, 16'hFFFF});
    pending_certs.push_back('{16'd97, 16'd2, 16'd3, 16'd3, 16'd91, 16'd2});
    pending_certs.push_back('{16'd97, 16'd2, 16'd3, 16'd3, 16'd0, 16'd3});
    pending_certs.push_back('{16'd97, 16'd195, 16'd100, 16'd200, 16'hFFFF, 16'd7});
    pending_certs.push_back('{16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFF});
    pending_certs.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000});
    pending_certs.push_back('{16'hFFF1, 16'd0, 16'd7, 16'h5555, 16'hAAAA, 16'h5555});
    pending_certs.push_back('{16'd5, 16'd1, 16'd1, 16'd0, 16'd1, 16'd6});
    pending_certs.push_back('{16'd3, 16'd2, 16'd2, 16'd2, 16'd2, 16'd12});
    pending_certs.push_back('{16'h8000, 16'h7FFF, 16'h1234, 16'h4321, 16'h0F0F, 16'h00FF});
    for (int i = 0; i < 300; i++) begin
      c = rand_cert($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 24) == 0) c.n = MW'($urandom_range(0, 1));
      pending_certs.push_back(c);
    end
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      {modulus, coef_a, coef_b, base_x, base_y, scalar} <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_verdicts.push_back(predict_verdict(
          '{modulus, coef_a, coef_b, base_x, base_y, scalar}));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        in_gap <= $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else if (pending_certs.size() > 0) begin
        {modulus, coef_a, coef_b, base_x, base_y, scalar} <= pending_certs.pop_front();
        in_valid <= 1'b1;
        if (pending_certs.size() < 40) calm <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", energy, 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (energy !== want.energy) report_mismatch("energy", energy, want.energy);
          if (certified !== want.certified)
            report_mismatch("certified", certified, want.certified);
          if (bad_modulus !== want.bad_modulus)
            report_mismatch("bad_modulus", bad_modulus, want.bad_modulus);
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_hold <= $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && expected_verdicts.size() == 0) && quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL ec_point_order_check_unit");
    end else begin
      repeat (50) @(posedge clk);
      if (error_count == 0) begin
        $display("PASS ec_point_order_check_unit");
      end else begin
        $display("FAIL ec_point_order_check_unit");
      end
    end
    $finish;
  end

endmodule
